>>> hdl/qsd_pkg.sv
// Shared types and constants for the Q16.16 saturating divider.
package qsd_pkg;

    localparam int unsigned WORD_W = 32;

    // Signed 32-bit clamp values for the quotient
    localparam logic [WORD_W-1:0] QUOT_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] QUOT_MIN = 32'h8000_0000;

    // Per-item control bits carried down the pipeline
    typedef struct packed {
        logic neg;   // operand signs differ
        logic div0;  // divisor was zero
        logic hi;    // quotient magnitude is at least 2^32
    } qsd_ctrl_t;

    // Working set of one item inside the divide stages
    typedef struct packed {
        logic [WORD_W-1:0] rem;   // partial remainder
        logic [WORD_W-1:0] nlow;  // low word of the scaled dividend magnitude
        logic [WORD_W-1:0] quo;   // quotient bits developed so far
        logic [WORD_W-1:0] dmag;  // divisor magnitude
        qsd_ctrl_t         ctrl;
    } qsd_div_t;

    // Finished result
    typedef struct packed {
        logic              saturated;
        logic              divide_by_zero;
        logic [WORD_W-1:0] quotient;
    } qsd_res_t;

endpackage

>>> hdl/qsd_prep.sv
// Operand preparation: magnitudes and signs, then scaling and high-overflow check.
module qsd_prep #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [qsd_pkg::WORD_W-1:0] dividend,
    input  logic signed [qsd_pkg::WORD_W-1:0] divisor,
    output logic                         out_valid,
    output qsd_pkg::qsd_div_t            out_data
);

    localparam int unsigned SCALED_W = qsd_pkg::WORD_W + FRACTION_BITS;

    logic [qsd_pkg::WORD_W-1:0] dvd_u;
    logic [qsd_pkg::WORD_W-1:0] dvs_u;
    logic [qsd_pkg::WORD_W-1:0] nmag_next;
    logic [qsd_pkg::WORD_W-1:0] dmag_next;
    qsd_pkg::qsd_ctrl_t         ctrl_next;

    logic                       v1_reg;
    logic [qsd_pkg::WORD_W-1:0] nmag_reg;
    logic [qsd_pkg::WORD_W-1:0] dmag_reg;
    qsd_pkg::qsd_ctrl_t         ctrl_reg;

    logic [SCALED_W-1:0]        scaled;
    logic [qsd_pkg::WORD_W-1:0] nhigh;
    qsd_pkg::qsd_div_t          div_next;

    logic                       v2_reg;
    qsd_pkg::qsd_div_t          div_reg;

    // Stage 1: two's complement magnitudes
    always_comb
    begin
        dvd_u     = dividend;
        dvs_u     = divisor;
        nmag_next = dvd_u[qsd_pkg::WORD_W-1] ? (~dvd_u + 1'b1) : dvd_u;
        dmag_next = dvs_u[qsd_pkg::WORD_W-1] ? (~dvs_u + 1'b1) : dvs_u;
        ctrl_next.neg  = dvd_u[qsd_pkg::WORD_W-1] ^ dvs_u[qsd_pkg::WORD_W-1];
        ctrl_next.div0 = (dvs_u == '0);
        ctrl_next.hi   = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg <= nmag_next;
            dmag_reg <= dmag_next;
            ctrl_reg <= ctrl_next;
        end
    end

    // Stage 2: scale dividend, split into remainder seed and low word
    always_comb
    begin
        scaled = SCALED_W'(nmag_reg) << FRACTION_BITS;
        nhigh  = qsd_pkg::WORD_W'(scaled >> qsd_pkg::WORD_W);
        div_next.rem     = nhigh;
        div_next.nlow    = scaled[qsd_pkg::WORD_W-1:0];
        div_next.quo     = '0;
        div_next.dmag    = dmag_reg;
        div_next.ctrl    = ctrl_reg;
        // quotient >= 2^32 exactly when the part above the low word covers the divisor
        div_next.ctrl.hi = (nhigh >= dmag_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = div_reg;

endmodule

>>> hdl/qsd_div_stage.sv
// One restoring-division step: develops a single quotient bit.
module qsd_div_stage #(
    parameter int unsigned BIT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  qsd_pkg::qsd_div_t in_data,
    output logic              out_valid,
    output qsd_pkg::qsd_div_t out_data
);

    logic [qsd_pkg::WORD_W:0]   shifted;
    logic [qsd_pkg::WORD_W:0]   trial;
    logic                       ge;
    qsd_pkg::qsd_div_t          data_next;

    logic                       valid_reg;
    qsd_pkg::qsd_div_t          data_reg;

    // Shift in the next dividend bit and try subtracting the divisor
    always_comb
    begin
        shifted = {in_data.rem, in_data.nlow[BIT]};
        trial   = shifted - {1'b0, in_data.dmag};
        ge      = (shifted >= {1'b0, in_data.dmag});
        data_next          = in_data;
        data_next.rem      = ge ? trial[qsd_pkg::WORD_W-1:0] : shifted[qsd_pkg::WORD_W-1:0];
        data_next.quo[BIT] = ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/qsd_post.sv
// Final stage: zero-divisor override, saturation and sign restore.
module qsd_post (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  qsd_pkg::qsd_div_t in_data,
    output logic              out_valid,
    output qsd_pkg::qsd_res_t out_data
);

    logic [qsd_pkg::WORD_W-1:0] qmag;
    logic [qsd_pkg::WORD_W-1:0] clamped;
    logic                       sat;
    qsd_pkg::qsd_res_t          res_next;

    logic                       valid_reg;
    qsd_pkg::qsd_res_t          res_reg;

    always_comb
    begin
        qmag = in_data.quo;
        if (in_data.ctrl.neg)
        begin
            sat     = in_data.ctrl.hi || (qmag > qsd_pkg::QUOT_MIN);
            clamped = sat ? qsd_pkg::QUOT_MIN : qmag;
        end
        else
        begin
            sat     = in_data.ctrl.hi || qmag[qsd_pkg::WORD_W-1];
            clamped = sat ? qsd_pkg::QUOT_MAX : qmag;
        end

        if (in_data.ctrl.div0)
        begin
            res_next.quotient       = '0;
            res_next.divide_by_zero = 1'b1;
            res_next.saturated      = 1'b0;
        end
        else
        begin
            res_next.quotient       = in_data.ctrl.neg ? (~clamped + 1'b1) : clamped;
            res_next.divide_by_zero = 1'b0;
            res_next.saturated      = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

endmodule

>>> hdl/qsd_skid.sv
// Two-entry output buffer with a registered ready toward the pipeline.
module qsd_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  qsd_pkg::qsd_res_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output qsd_pkg::qsd_res_t out_data
);

    logic              main_valid_reg;
    logic              spare_valid_reg;
    qsd_pkg::qsd_res_t main_reg;
    qsd_pkg::qsd_res_t spare_reg;
    logic              main_load;

    // Main register frees up when empty or when its transfer completes
    assign main_load = !main_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (main_load)
        begin
            if (spare_valid_reg)
            begin
                main_valid_reg  <= 1'b1;
                spare_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= in_valid;
            end
        end
        else if (in_valid && !spare_valid_reg)
        begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_load)
        begin
            main_reg <= spare_valid_reg ? spare_reg : in_data;
        end
        else if (!spare_valid_reg)
        begin
            spare_reg <= in_data;
        end
    end

    assign in_ready  = !spare_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

>>> hdl/q16_16_saturating_divider.sv
// Top level of the pipelined Q16.16 saturating divider.
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  tdata: dividend, divisor
//  m_*      out  m_tvalid/m_tready  tdata: quotient; tuser: divide_by_zero, saturated
//
// One transfer accepted per cycle while s_tready is high; each gives exactly one result
// via two preparation stages, one stage per quotient bit, a result stage, output register.
// The depth is set by the restoring divider, one 33-bit subtract per quotient bit.
// rst_n clears all valid bits asynchronously; data registers are not reset.
// On output stall a two-entry buffer absorbs one more result, then the whole
// pipeline holds; s_tready is a register output.
module q16_16_saturating_divider #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] dividend, [63:32] divisor
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] quotient
    output logic [1:0]  m_tuser    // [0] divide_by_zero, [1] saturated
);

    localparam int unsigned STEPS = qsd_pkg::WORD_W;

    logic                adv;
    logic                step_valid [0:STEPS];
    qsd_pkg::qsd_div_t   step_data  [0:STEPS];
    logic                post_valid;
    qsd_pkg::qsd_res_t   post_data;
    qsd_pkg::qsd_res_t   res;

    // Preparation stages
    qsd_prep #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_tvalid),
        .dividend  (s_tdata[31:0]),
        .divisor   (s_tdata[63:32]),
        .out_valid (step_valid[0]),
        .out_data  (step_data[0])
    );

    // One divide stage per quotient bit, most significant first
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        qsd_div_stage #(
            .BIT (STEPS - 1 - i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (step_valid[i]),
            .in_data   (step_data[i]),
            .out_valid (step_valid[i+1]),
            .out_data  (step_data[i+1])
        );
    end

    // Saturation and sign
    qsd_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (step_valid[STEPS]),
        .in_data   (step_data[STEPS]),
        .out_valid (post_valid),
        .out_data  (post_data)
    );

    // Output buffer; its ready moves the whole pipeline
    qsd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (post_valid),
        .in_ready  (adv),
        .in_data   (post_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign s_tready = adv;
    assign m_tdata  = res.quotient;
    assign m_tuser  = {res.saturated, res.divide_by_zero};

endmodule

>>> sim/q16_16_saturating_divider_tb.sv
// Self-checking testbench for the Q16.16 saturating divider: directed and random divisions.
module q16_16_saturating_divider_tb;

    localparam int unsigned FRAC_BITS    = 16;
    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned LONG_HOLD    = 400;

    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] LSB_NEG   = 32'hFFFF_FFFF;
    localparam logic [31:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN  = 32'h8000_0000;

    // One division in flight: operands and the result it must produce
    typedef struct {
        logic [31:0]       dividend;
        logic [31:0]       divisor;
        qsd_pkg::qsd_res_t res;
    } division_t;

    // Directed row; res is only meaningful when is_typed is set
    typedef struct {
        logic [31:0]       dividend;
        logic [31:0]       divisor;
        bit                is_typed;
        qsd_pkg::qsd_res_t res;
    } stim_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;     // [31:0] dividend, [63:32] divisor
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] quotient
    logic [1:0]  m_tuser;           // [0] divide_by_zero, [1] saturated

    division_t   pending_quotients[$];
    stim_row_t   directed_rows[$];
    division_t   oldest;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned results_seen   = 0;
    int unsigned hold_cycles    = 0;
    int unsigned rx_gap;
    bit          long_hold_done = 1'b0;
    bit          rx_burst       = 1'b0;
    bit          tx_burst       = 1'b0;

    q16_16_saturating_divider #(
        .FRACTION_BITS(FRAC_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Scaled sign-magnitude division, truncated toward zero, clamped to 32 bits
    function automatic qsd_pkg::qsd_res_t divide_q16(input logic [31:0] num,
                                                     input logic [31:0] den);
        logic              num_neg;
        logic              den_neg;
        logic [63:0]       num_mag;
        logic [63:0]       den_mag;
        logic [63:0]       quo_mag;
        qsd_pkg::qsd_res_t res;
        res     = '0;
        num_neg = num[31];
        den_neg = den[31];
        // negating the most negative word leaves 0x80000000, which is 2^31 unsigned
        num_mag = {32'd0, (num_neg ? -num : num)};
        den_mag = {32'd0, (den_neg ? -den : den)};
        if (den_mag == 64'd0)
        begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        quo_mag = (num_mag << FRAC_BITS) / den_mag;
        if (num_neg == den_neg)
        begin
            if (quo_mag > {32'd0, WORD_MAX})
            begin
                quo_mag       = {32'd0, WORD_MAX};
                res.saturated = 1'b1;
            end
            res.quotient = quo_mag[31:0];
        end
        else
        begin
            if (quo_mag > {32'd0, WORD_MIN})
            begin
                quo_mag       = {32'd0, WORD_MIN};
                res.saturated = 1'b1;
            end
            res.quotient = -quo_mag[31:0];
        end
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return LSB_NEG;
            3: return WORD_MAX;
            4: return WORD_MIN;
            5: return Q_ONE;
            6: return Q_NEG_ONE;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic add_row(input logic [31:0] dividend, input logic [31:0] divisor,
                           input bit is_typed, input logic [31:0] quotient,
                           input logic div0, input logic sat);
        stim_row_t row;
        row.dividend           = dividend;
        row.divisor            = divisor;
        row.is_typed           = is_typed;
        row.res.quotient       = quotient;
        row.res.divide_by_zero = div0;
        row.res.saturated      = sat;
        directed_rows.push_back(row);
    endtask

    // Directed table: typed where the answer is obvious, predicted otherwise
    task automatic build_directed_rows();
        // zero divisor
        add_row(32'd0,         32'd0,         1, 32'd0,    1, 0);
        add_row(WORD_MAX,      32'd0,         1, 32'd0,    1, 0);
        add_row(WORD_MIN,      32'd0,         1, 32'd0,    1, 0);
        // plain unit and extremes
        add_row(Q_ONE,         Q_ONE,         1, Q_ONE,    0, 0);
        add_row(WORD_MAX,      32'd1,         1, WORD_MAX, 0, 1);
        add_row(WORD_MIN,      32'd1,         1, WORD_MIN, 0, 1);
        add_row(WORD_MAX,      LSB_NEG,       1, WORD_MIN, 0, 1);
        add_row(WORD_MIN,      LSB_NEG,       1, WORD_MAX, 0, 1);
        add_row(WORD_MIN,      Q_NEG_ONE,     1, WORD_MAX, 0, 1);
        // exactly the most negative value, no clamp, then unit ratios and a zero dividend
        add_row(WORD_MIN,      Q_ONE,         1, WORD_MIN, 0, 0);
        add_row(32'hC000_0000, 32'h0000_8000, 1, WORD_MIN, 0, 0);
        add_row(WORD_MIN,      WORD_MIN,      1, Q_ONE,    0, 0);
        add_row(WORD_MAX,      WORD_MAX,      1, Q_ONE,    0, 0);
        add_row(32'd0,         WORD_MIN,      1, 32'd0,    0, 0);
        // tiny quotients with differing signs give plain zero
        add_row(32'd1,         32'h8000_0001, 1, 32'd0,    0, 0);
        add_row(LSB_NEG,       WORD_MAX,      1, 32'd0,    0, 0);
        add_row(32'd1,         WORD_MIN,      1, 32'd0,    0, 0);
        // one LSB past the positive limit
        add_row(32'h4000_0000, 32'h0000_8000, 1, WORD_MAX, 0, 1);
        // around the saturation boundary and truncation
        add_row(32'h3FFF_FFFF, 32'h0000_8000, 0, '0, 0, 0);
        add_row(32'hC000_0001, 32'h0000_8000, 0, '0, 0, 0);
        add_row(32'h0007_0000, 32'h0003_0000, 0, '0, 0, 0);
        add_row(32'hFFF9_0000, 32'h0003_0000, 0, '0, 0, 0);
        add_row(32'hFFFD_0000, 32'h0002_0000, 0, '0, 0, 0);
        // alternating bit patterns
        add_row(32'hAAAA_AAAA, 32'h5555_5555, 0, '0, 0, 0);
        add_row(32'h5555_5555, 32'hAAAA_AAAA, 0, '0, 0, 0);
    endtask

    // Operand mix: full random, near the clamp point, small, zero divisor, extremes
    task automatic gen_random_pair(output logic [31:0] dividend, output logic [31:0] divisor);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic        [31:0] r;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4:
            begin
                b = $urandom_range(1, 16'hFFFF);
                if ($urandom_range(0, 1))
                    b = -b;
            end
            5:
            begin
                b = a >>> 15;
                b = b + $urandom_range(0, 4) - 2;
                if ($urandom_range(0, 1))
                    b = -b;
            end
            6:
            begin
                r = $urandom;
                a = {{12{r[19]}}, r[19:0]};
                r = $urandom;
                b = {{12{r[19]}}, r[19:0]};
            end
            7: b = '0;
            8:
            begin
                a = pick_extreme();
                b = pick_extreme();
            end
            default:
            begin
                r = $urandom;
                a = {{8{r[23]}}, r[23:0]};
            end
        endcase
        dividend = a;
        divisor  = b;
    endtask

    // Offer one division and wait for its transfer; holds tvalid across back-to-back items
    task automatic send_division(input logic [31:0] dividend, input logic [31:0] divisor,
                                 input bit is_typed, input qsd_pkg::qsd_res_t typed_res);
        int unsigned gap;
        division_t   item;
        if ($urandom_range(0, 99) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {divisor, dividend};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        item.dividend = dividend;
        item.divisor  = divisor;
        item.res      = is_typed ? typed_res : divide_q16(dividend, divisor);
        pending_quotients.push_back(item);
    endtask

    // Receiver ready: random stalls, burst stretches, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_cycles != 0)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (!long_hold_done && results_seen >= 200)
        begin
            m_tready       <= 1'b0;
            hold_cycles    <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                rx_burst <= !rx_burst;
            rx_gap = rx_burst ? 0 : pick_gap();
            if (rx_gap == 0)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready    <= 1'b0;
                hold_cycles <= rx_gap - 1;
            end
        end
    end

    // Result check against the oldest pending division
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (pending_quotients.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result q=%h flags=%b", m_tdata, m_tuser));
            end
            else
            begin
                oldest = pending_quotients.pop_front();
                if (m_tdata !== oldest.res.quotient)
                    report_mismatch($sformatf("%h / %h: quotient %h, want %h",
                        oldest.dividend, oldest.divisor, m_tdata, oldest.res.quotient));
                if (m_tuser[0] !== oldest.res.divide_by_zero)
                    report_mismatch($sformatf("%h / %h: divide_by_zero %b, want %b",
                        oldest.dividend, oldest.divisor, m_tuser[0],
                        oldest.res.divide_by_zero));
                if (m_tuser[1] !== oldest.res.saturated)
                    report_mismatch($sformatf("%h / %h: saturated %b, want %b",
                        oldest.dividend, oldest.divisor, m_tuser[1], oldest.res.saturated));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] dd;
        logic [31:0] dv;
        build_directed_rows();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
            send_division(directed_rows[i].dividend, directed_rows[i].divisor,
                          directed_rows[i].is_typed, directed_rows[i].res);

        // random divisions
        repeat (RANDOM_ITEMS)
        begin
            gen_random_pair(dd, dv);
            send_division(dd, dv, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending_quotients.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
